FILE: rtl/core/tbn_pkg.sv
package tbn_pkg;

   localparam int MAX_NODES = 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] MODE_LOCAL   = 2'd0;
   localparam logic [1:0] MODE_ARRIVE  = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   localparam logic [1:0] SEND_NONE    = 2'd0;
   localparam logic [1:0] SEND_ARRIVE  = 2'd1;
   localparam logic [1:0] SEND_RELEASE = 2'd2;

   localparam logic CSR_RANK  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_GATHER,
      PH_WAITREL
   } phase_type;

   typedef enum logic {
      JOB_SINGLE,
      JOB_RELEASE
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   send_kind;
      logic [5:0]   dest_rank;
      logic         done;
      logic         has_child;
      logic [2:0]   upto;
      logic [5:0]   rank;
   } job_type;

endpackage

FILE: rtl/core/tournament_barrier_node.sv
// Channel  | Direction | Transfer contents
// ---------+-----------+--------------------------------------------------------
// req_     | in        | tuser: mode; tdata: peer_rank
// rsp_     | out       | tuser: send_kind; tdata: dest_rank, barrier_done; tlast: last
// csr_     | in/out    | 0x0 node_rank, 0x4 node_count; pready tied high
//
// The front takes one transfer per cycle while its two-entry job queue has room.
// The back registers each job, then emits one result per cycle while rsp_ is ready:
// one result, or up to six releases (child first, then beaten partners by round).
// The first result passes the queue, the job register and the output register.
// Synchronous reset clears barrier state, the queue and the output valid flag.
// A stalled rsp_ holds its result; the front keeps taking inputs until the queue fills.
module tournament_barrier_node #(
   parameter int MAX_NODES = tbn_pkg::MAX_NODES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic [7:0]  req_tdata,   // [5:0] peer_rank, [7:6] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] send_kind
   output logic [7:0]  rsp_tdata,   // [5:0] dest_rank, [6] barrier_done, [7] zero
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic             q_full;
   logic             q_push;
   tbn_pkg::job_type q_push_job;
   logic             q_pop;
   logic             q_valid;
   tbn_pkg::job_type q_pop_job;

   tbn_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_push_job)
   );

   tbn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_pop_job)
   );

   tbn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job        (q_pop_job),
      .job_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/tbn_front.sv
module tbn_front #(
   parameter int MAX_NODES = tbn_pkg::MAX_NODES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_tuser,
   input  logic [7:0]       req_tdata,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   input  logic             q_full,
   output logic             q_push,
   output tbn_pkg::job_type q_job
);

   localparam int EFF_LIMIT = (MAX_NODES < 64) ? MAX_NODES : 64;
   localparam logic [6:0] EFF_MAX = 7'(EFF_LIMIT);

   logic [5:0]          rank_ff;
   logic [6:0]          count_ff;
   tbn_pkg::phase_type  phase_ff, phase_in;
   logic [6:0]          arrived_ff, arrived_in;
   logic [2:0]          round_ff, round_in;

   logic [6:0] eff;
   logic [2:0] rounds;
   logic [6:0] pow;
   logic [6:0] gap;
   logic       has_child;
   logic       trivial;
   logic       below_p;
   logic       accept;
   logic       cfg_wr;
   logic [1:0] mode;
   logic [5:0] peer;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == tbn_pkg::CSR_COUNT) ? {25'd0, count_ff}
                                                          : {26'd0, rank_ff};

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & req_tready;
   assign mode       = req_tuser;
   assign peer       = req_tdata[5:0];

   always_comb begin
      if (count_ff == 7'd0) begin
         eff = 7'd1;
      end else if (count_ff > EFF_MAX) begin
         eff = EFF_MAX;
      end else begin
         eff = count_ff;
      end
   end

   always_comb begin
      rounds = 3'd0;
      for (int b = 1; b < 7; b++) begin
         if (eff[b]) begin
            rounds = 3'(b);
         end
      end
   end

   assign pow       = 7'd1 << rounds;
   assign gap       = eff - pow;
   assign has_child = {1'b0, rank_ff} < gap;
   assign trivial   = (eff == 7'd1) || ({1'b0, rank_ff} >= eff);
   assign below_p   = {1'b0, rank_ff} < pow;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= 6'd0;
         count_ff <= 7'd1;
      end else if (cfg_wr) begin
         case (csr_paddr[2])
            tbn_pkg::CSR_RANK:  rank_ff  <= csr_pwdata[5:0];
            tbn_pkg::CSR_COUNT: count_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tbn_pkg::PH_IDLE;
         arrived_ff <= 7'd0;
         round_ff   <= 3'd0;
      end else begin
         phase_ff   <= phase_in;
         arrived_ff <= arrived_in;
         round_ff   <= round_in;
      end
   end

   always_comb begin
      logic [6:0] arr_n;
      logic [6:0] new_bit;
      logic [5:0] diff;
      logic       part_hit;
      logic [2:0] part_i;
      logic       is_child;
      logic [2:0] start;
      logic       stop_found;
      logic [2:0] stop_j;
      logic       do_adv;
      logic       fin;
      logic       fin_list;
      logic [2:0] fin_upto;

      phase_in   = phase_ff;
      arrived_in = arrived_ff;
      round_in   = round_ff;
      q_push     = 1'b0;
      q_job      = '0;
      q_job.rank = rank_ff;
      do_adv     = 1'b0;
      fin        = 1'b0;
      fin_list   = 1'b0;
      fin_upto   = 3'd0;

      is_child = has_child && ({1'b0, peer} == 7'({1'b0, rank_ff} + pow));
      diff     = peer ^ rank_ff;
      part_hit = 1'b0;
      part_i   = 3'd0;
      for (int i = 0; i < 6; i++) begin
         if (!part_hit && 3'(i) < rounds && diff == (6'd1 << i) && !rank_ff[i]) begin
            part_hit = 1'b1;
            part_i   = 3'(i);
         end
      end
      new_bit = is_child ? 7'h40 : (part_hit ? (7'd1 << part_i) : 7'd0);
      arr_n   = arrived_ff;
      start   = round_ff;

      if (accept) begin
         case (mode)
            tbn_pkg::MODE_LOCAL: begin
               if (phase_ff == tbn_pkg::PH_IDLE) begin
                  if (trivial) begin
                     fin = 1'b1;
                  end else if (!below_p) begin
                     phase_in        = tbn_pkg::PH_WAITREL;
                     q_push          = 1'b1;
                     q_job.kind      = tbn_pkg::JOB_SINGLE;
                     q_job.send_kind = tbn_pkg::SEND_ARRIVE;
                     q_job.dest_rank = 6'({1'b0, rank_ff} - pow);
                  end else begin
                     phase_in = tbn_pkg::PH_GATHER;
                     round_in = 3'd0;
                     start    = 3'd0;
                     do_adv   = 1'b1;
                  end
               end
            end
            tbn_pkg::MODE_ARRIVE: begin
               if (!trivial && below_p && new_bit != 7'd0 &&
                   (arrived_ff & new_bit) == 7'd0) begin
                  arr_n      = arrived_ff | new_bit;
                  arrived_in = arr_n;
                  do_adv     = (phase_ff == tbn_pkg::PH_GATHER);
               end
            end
            tbn_pkg::MODE_RELEASE: begin
               if (phase_ff == tbn_pkg::PH_WAITREL && !trivial) begin
                  if (!below_p) begin
                     fin = 1'b1;
                  end else if (round_ff < rounds && peer == (rank_ff ^ (6'd1 << round_ff))) begin
                     fin      = 1'b1;
                     fin_list = 1'b1;
                     fin_upto = round_ff;
                  end
               end
            end
            default: ;
         endcase
      end

      stop_found = 1'b0;
      stop_j     = 3'd0;
      for (int j = 0; j < 6; j++) begin
         if (!stop_found && 3'(j) >= start && 3'(j) < rounds && (rank_ff[j] || !arr_n[j])) begin
            stop_found = 1'b1;
            stop_j     = 3'(j);
         end
      end

      if (do_adv && !(has_child && !arr_n[6])) begin
         if (stop_found) begin
            round_in = stop_j;
            if (rank_ff[stop_j]) begin
               phase_in        = tbn_pkg::PH_WAITREL;
               q_push          = 1'b1;
               q_job.kind      = tbn_pkg::JOB_SINGLE;
               q_job.send_kind = tbn_pkg::SEND_ARRIVE;
               q_job.dest_rank = rank_ff ^ (6'd1 << stop_j);
            end
         end else begin
            fin      = 1'b1;
            fin_list = 1'b1;
            fin_upto = rounds;
         end
      end

      if (fin) begin
         phase_in   = tbn_pkg::PH_IDLE;
         arrived_in = 7'd0;
         round_in   = 3'd0;
         q_push     = 1'b1;
         if (fin_list && (has_child || fin_upto != 3'd0)) begin
            q_job.kind      = tbn_pkg::JOB_RELEASE;
            q_job.send_kind = tbn_pkg::SEND_RELEASE;
            q_job.dest_rank = 6'({1'b0, rank_ff} + pow);
            q_job.has_child = has_child;
            q_job.upto      = fin_upto;
         end else begin
            q_job.kind      = tbn_pkg::JOB_SINGLE;
            q_job.send_kind = tbn_pkg::SEND_NONE;
            q_job.dest_rank = 6'd0;
            q_job.done      = 1'b1;
         end
      end

      if (cfg_wr) begin
         phase_in   = tbn_pkg::PH_IDLE;
         arrived_in = 7'd0;
         round_in   = 3'd0;
      end
   end

endmodule

FILE: rtl/core/tbn_queue.sv
module tbn_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tbn_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output tbn_pkg::job_type pop_job
);

   tbn_pkg::job_type              entry_ff [tbn_pkg::QUEUE_DEPTH];
   logic [tbn_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tbn_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tbn_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   localparam logic [tbn_pkg::QPTR_W-1:0] PTR_LAST = tbn_pkg::QPTR_W'(tbn_pkg::QUEUE_DEPTH - 1);
   localparam logic [tbn_pkg::QCNT_W-1:0] CNT_FULL = tbn_pkg::QCNT_W'(tbn_pkg::QUEUE_DEPTH);

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/tbn_back.sv
module tbn_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  tbn_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [1:0]       rsp_tuser,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   logic             busy_ff, busy_in;
   tbn_pkg::job_type cur_ff, cur_in;
   logic             child_ff, child_in;
   logic [2:0]       idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic [5:0]       out_dest_ff, out_dest_in;
   logic             out_done_ff, out_done_in;
   logic             out_last_ff, out_last_in;
   logic             slot_free;
   logic             emit;

   assign slot_free  = ~out_valid_ff | rsp_tready;
   assign job_pop    = job_valid & ~busy_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {1'b0, out_done_ff, out_dest_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      busy_in     = busy_ff;
      cur_in      = cur_ff;
      child_in    = child_ff;
      idx_in      = idx_ff;
      out_kind_in = out_kind_ff;
      out_dest_in = out_dest_ff;
      out_done_in = out_done_ff;
      out_last_in = out_last_ff;
      emit        = 1'b0;

      if (busy_ff && slot_free) begin
         emit = 1'b1;
         if (cur_ff.kind == tbn_pkg::JOB_SINGLE) begin
            out_kind_in = cur_ff.send_kind;
            out_dest_in = cur_ff.dest_rank;
            out_done_in = cur_ff.done;
            out_last_in = 1'b1;
            busy_in     = 1'b0;
         end else begin
            out_kind_in = tbn_pkg::SEND_RELEASE;
            if (child_ff) begin
               out_dest_in = cur_ff.dest_rank;
               out_last_in = (cur_ff.upto == 3'd0);
               child_in    = 1'b0;
            end else begin
               out_dest_in = cur_ff.rank ^ (6'd1 << idx_ff);
               out_last_in = (3'(idx_ff + 3'd1) == cur_ff.upto);
               idx_in      = 3'(idx_ff + 3'd1);
            end
            out_done_in = out_last_in;
            if (out_last_in) begin
               busy_in = 1'b0;
            end
         end
      end

      if (job_pop) begin
         busy_in  = 1'b1;
         cur_in   = job;
         child_in = job.has_child;
         idx_in   = 3'd0;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      child_ff    <= child_in;
      idx_ff      <= idx_in;
      out_kind_ff <= out_kind_in;
      out_dest_ff <= out_dest_in;
      out_done_ff <= out_done_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: rtl/core/tbn_checker.sv
module tbn_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transfer dropped or changed while stalled");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tlast)
      else $error("barrier_done without last");

   a_none_means_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tbn_pkg::SEND_NONE |->
         rsp_tdata[5:0] == 6'd0 && rsp_tdata[6] && rsp_tlast)
      else $error("empty result not a clean finish");

   a_arrive_is_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tbn_pkg::SEND_ARRIVE |-> rsp_tlast && !rsp_tdata[6])
      else $error("arrive send not a lone, unfinished result");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready low");

endmodule

bind tournament_barrier_node tbn_checker u_tbn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

FILE: verif/tournament_barrier_node_tb.sv
`timescale 1ns / 1ps

module tournament_barrier_node_tb;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 250;

   typedef struct packed {
      logic [1:0] send_kind;
      logic [5:0] dest_rank;
      logic       barrier_done;
      logic       last_flag;
   } barrier_msg_type;

   typedef struct packed {
      logic            is_cfg;
      logic [5:0]      rank;
      logic [6:0]      count;
      logic [1:0]      mode;
      logic [5:0]      peer;
      logic            typed;
      barrier_msg_type want;
   } dir_row_type;

   localparam barrier_msg_type NO_MSG = '0;
   localparam barrier_msg_type DONE_MSG = '{tbn_pkg::SEND_NONE, 6'd0, 1'b1, 1'b1};
   localparam int NUM_DIR = 33;

   localparam dir_row_type DIR_ROWS [NUM_DIR] = '{
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b1, DONE_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd63, 1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_RELEASE, 6'd63, 1'b0, NO_MSG},
      '{1'b1, 6'd63, 7'd64,  tbn_pkg::MODE_LOCAL,   6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b1,
        '{tbn_pkg::SEND_ARRIVE, 6'd62, 1'b0, 1'b1}},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_RELEASE, 6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_RELEASE, 6'd62, 1'b1, DONE_MSG},
      '{1'b1, 6'd0,  7'd64,  tbn_pkg::MODE_LOCAL,   6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd1,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd2,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd4,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd8,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd16, 1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd32, 1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd1,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd63, 1'b0, NO_MSG},
      '{1'b1, 6'd0,  7'd127, tbn_pkg::MODE_LOCAL,   6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd63, 1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd63, 1'b0, NO_MSG},
      '{1'b1, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd21, 1'b1, DONE_MSG},
      '{1'b1, 6'd0,  7'd3,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd42, 1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd2,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_ARRIVE,  6'd1,  1'b0, NO_MSG},
      '{1'b1, 6'd5,  7'd6,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   MODE_UNUSED,           6'd1,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b1,
        '{tbn_pkg::SEND_ARRIVE, 6'd1, 1'b0, 1'b1}},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_RELEASE, 6'd33, 1'b1, DONE_MSG},
      '{1'b1, 6'd10, 7'd5,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b0, NO_MSG},
      '{1'b0, 6'd0,  7'd0,   tbn_pkg::MODE_LOCAL,   6'd0,  1'b1, DONE_MSG},
      '{1'b0, 6'd0,  7'd0,   MODE_UNUSED,           6'd63, 1'b0, NO_MSG}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic        hold_req = 1'b0;
   logic        hold_done = 1'b0;

   tbn_pkg::phase_type bar_phase;
   logic [6:0]         arrived;
   logic [2:0]         cur_round;
   logic [5:0]         cfg_rank;
   logic [6:0]         cfg_count;
   barrier_msg_type    step_msgs [$];
   barrier_msg_type    due_msgs [$];
   int                 mismatch_count = 0;
   int                 random_sent = 0;
   int                 burst_left = 0;

   tournament_barrier_node i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_nodes();
      int unsigned c;
      c = cfg_count;
      if (c < 1) c = 1;
      if (c > tbn_pkg::MAX_NODES) c = tbn_pkg::MAX_NODES;
      if (c > 64) c = 64;
      return c;
   endfunction

   function automatic int unsigned round_count(int unsigned c);
      int unsigned r;
      r = 0;
      while (r < 6 && (2 << r) <= c) r++;
      return r;
   endfunction

   function automatic void clear_barrier();
      bar_phase = tbn_pkg::PH_IDLE;
      arrived = '0;
      cur_round = '0;
   endfunction

   function automatic void add_msg(logic [1:0] kind, int unsigned dest, logic done,
                                   logic lst);
      barrier_msg_type m;
      m.send_kind = kind;
      m.dest_rank = 6'(dest);
      m.barrier_done = done;
      m.last_flag = lst;
      step_msgs.push_back(m);
   endfunction

   function automatic void finish_barrier(bit release_list, int unsigned upto);
      int unsigned rank, c, p, i;
      barrier_msg_type m;
      rank = cfg_rank;
      c = eff_nodes();
      p = 1 << round_count(c);
      if (release_list) begin
         if (rank < c - p) add_msg(tbn_pkg::SEND_RELEASE, rank + p, 1'b0, 1'b0);
         for (i = 0; i < upto && i < 6; i++)
            add_msg(tbn_pkg::SEND_RELEASE, rank ^ (1 << i), 1'b0, 1'b0);
      end
      if (step_msgs.size() == 0) begin
         add_msg(tbn_pkg::SEND_NONE, 0, 1'b1, 1'b1);
      end else begin
         m = step_msgs.pop_back();
         m.barrier_done = 1'b1;
         m.last_flag = 1'b1;
         step_msgs.push_back(m);
      end
      clear_barrier();
   endfunction

   function automatic void advance_rounds();
      int unsigned rank, c, r, p, i, partner;
      rank = cfg_rank;
      c = eff_nodes();
      r = round_count(c);
      p = 1 << r;
      i = cur_round;
      if (rank < c - p && !arrived[6]) return;
      while (i < r) begin
         partner = rank ^ (1 << i);
         if (partner < rank) begin
            bar_phase = tbn_pkg::PH_WAITREL;
            cur_round = 3'(i);
            add_msg(tbn_pkg::SEND_ARRIVE, partner, 1'b0, 1'b1);
            return;
         end
         if (!arrived[i]) begin
            cur_round = 3'(i);
            return;
         end
         i++;
      end
      finish_barrier(1'b1, r);
   endfunction

   function automatic void predict_step(logic [1:0] mode, logic [5:0] peer);
      int unsigned rank, c, r, p, i;
      bit trivial, hit;
      step_msgs.delete();
      rank = cfg_rank;
      c = eff_nodes();
      r = round_count(c);
      p = 1 << r;
      trivial = (c == 1) || (rank >= c);
      if (mode == tbn_pkg::MODE_LOCAL) begin
         if (bar_phase != tbn_pkg::PH_IDLE) return;
         if (trivial) begin
            finish_barrier(1'b0, 0);
         end else if (rank >= p) begin
            bar_phase = tbn_pkg::PH_WAITREL;
            add_msg(tbn_pkg::SEND_ARRIVE, rank - p, 1'b0, 1'b1);
         end else begin
            bar_phase = tbn_pkg::PH_GATHER;
            cur_round = '0;
            advance_rounds();
         end
      end else if (mode == tbn_pkg::MODE_ARRIVE) begin
         if (trivial || rank >= p) return;
         if (rank < c - p && peer == rank + p) begin
            if (arrived[6]) return;
            arrived[6] = 1'b1;
         end else begin
            hit = 1'b0;
            for (i = 0; i < r; i++) begin
               if (peer == (rank ^ (1 << i)) && peer > rank) begin
                  if (arrived[i]) return;
                  arrived[i] = 1'b1;
                  hit = 1'b1;
                  break;
               end
            end
            if (!hit) return;
         end
         if (bar_phase == tbn_pkg::PH_GATHER) advance_rounds();
      end else if (mode == tbn_pkg::MODE_RELEASE) begin
         if (bar_phase != tbn_pkg::PH_WAITREL || trivial) return;
         if (rank >= p) begin
            finish_barrier(1'b0, 0);
         end else if (cur_round < r && peer == (rank ^ (1 << cur_round))) begin
            finish_barrier(1'b1, cur_round);
         end
      end
   endfunction

   task automatic csr_write(logic idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == tbn_pkg::CSR_RANK) cfg_rank = value[5:0];
      else cfg_count = value[6:0];
      clear_barrier();
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_msgs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(logic [1:0] mode, logic [5:0] peer, bit typed,
                            barrier_msg_type want);
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {2'b00, peer};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_step(mode, peer);
      if (typed) due_msgs.push_back(want);
      else foreach (step_msgs[k]) due_msgs.push_back(step_msgs[k]);
   endtask

   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(16, 1);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_random(logic [1:0] mode, logic [5:0] peer);
      send_item(mode, peer, 1'b0, NO_MSG);
      random_sent++;
      pace();
   endtask

   task automatic run_random_phase();
      logic [1:0]  um [$];
      logic [5:0]  up [$];
      logic [1:0]  tm;
      logic [5:0]  tp;
      logic [6:0]  new_count;
      logic [5:0]  new_rank;
      int unsigned c, r, p, rank, reps, lost, pick, sel;
      int          k, j;
      pick = $urandom_range(99, 0);
      if (pick < 12) begin
         sel = $urandom_range(5, 0);
         case (sel)
            0: new_count = 7'd0;
            1: new_count = 7'd1;
            2: new_count = 7'd2;
            3: new_count = 7'd63;
            4: new_count = 7'd64;
            default: new_count = 7'd127;
         endcase
      end else if (pick < 85) begin
         new_count = 7'($urandom_range(64, 2));
      end else begin
         new_count = 7'($urandom_range(127, 0));
      end
      c = (new_count < 1) ? 1 : ((new_count > 64) ? 64 : new_count);
      if (c > 1 && $urandom_range(9, 0) < 8) new_rank = 6'($urandom_range(c - 1, 0));
      else new_rank = 6'($urandom_range(63, 0));
      wait_idle();
      if ($urandom_range(1, 0)) begin
         csr_write(tbn_pkg::CSR_RANK, {26'd0, new_rank});
         csr_write(tbn_pkg::CSR_COUNT, {25'd0, new_count});
      end else begin
         csr_write(tbn_pkg::CSR_COUNT, {25'd0, new_count});
         csr_write(tbn_pkg::CSR_RANK, {26'd0, new_rank});
      end
      c = eff_nodes();
      r = round_count(c);
      p = 1 << r;
      rank = cfg_rank;
      reps = $urandom_range(3, 1);
      repeat (reps) begin
         um.delete();
         up.delete();
         um.push_back(tbn_pkg::MODE_LOCAL);
         up.push_back(6'($urandom));
         if (rank < p) begin
            if (rank < c - p) begin
               um.push_back(tbn_pkg::MODE_ARRIVE);
               up.push_back(6'(rank + p));
            end
            lost = r;
            for (k = 0; k < r; k++) begin
               if ((rank ^ (1 << k)) > rank) begin
                  um.push_back(tbn_pkg::MODE_ARRIVE);
                  up.push_back(6'(rank ^ (1 << k)));
               end else if (lost == r) begin
                  lost = k;
               end
            end
            um.push_back(tbn_pkg::MODE_RELEASE);
            up.push_back((lost < r) ? 6'(rank ^ (1 << lost)) : 6'($urandom));
         end else begin
            um.push_back(tbn_pkg::MODE_RELEASE);
            up.push_back(6'($urandom));
         end
         for (k = um.size() - 1; k > 0; k--) begin
            j = $urandom_range(k, 0);
            tm = um[k];
            um[k] = um[j];
            um[j] = tm;
            tp = up[k];
            up[k] = up[j];
            up[j] = tp;
         end
         for (k = 0; k < um.size(); k++) begin
            if ($urandom_range(3, 0) == 0) send_random(2'($urandom), 6'($urandom));
            send_random(um[k], up[k]);
         end
      end
   endtask

   initial begin
      int n;
      cfg_rank = '0;
      cfg_count = 7'd1;
      clear_barrier();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < NUM_DIR; n++) begin
         if (DIR_ROWS[n].is_cfg) begin
            wait_idle();
            csr_write(tbn_pkg::CSR_RANK, {26'd0, DIR_ROWS[n].rank});
            csr_write(tbn_pkg::CSR_COUNT, {25'd0, DIR_ROWS[n].count});
         end else begin
            send_item(DIR_ROWS[n].mode, DIR_ROWS[n].peer, DIR_ROWS[n].typed,
                      DIR_ROWS[n].want);
            pace();
         end
      end

      wait_idle();
      csr_write(tbn_pkg::CSR_RANK, 32'd3);
      csr_write(tbn_pkg::CSR_COUNT, 32'd1);
      hold_req <= 1'b1;
      repeat (24) send_item(tbn_pkg::MODE_LOCAL, 6'($urandom), 1'b0, NO_MSG);

      while (random_sent < RANDOM_ITEMS) run_random_phase();

      wait_idle();
      if (mismatch_count == 0 && due_msgs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      int style, span, hold_cnt;
      hold_cnt = 0;
      @(negedge reset);
      forever begin
         style = $urandom_range(2, 0);
         span = $urandom_range(60, 5);
         repeat (span) begin
            @(posedge clock);
            if (hold_req && !hold_done) begin
               rsp_tready <= 1'b0;
               hold_cnt++;
               if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
            end else begin
               case (style)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom);
                  default: rsp_tready <= ($urandom_range(3, 0) == 0);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      barrier_msg_type exp_msg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_msgs.size() == 0) begin
            $error("unexpected result: send_kind %0d dest_rank %0d", rsp_tuser,
                   rsp_tdata[5:0]);
            mismatch_count++;
         end else begin
            exp_msg = due_msgs.pop_front();
            if (rsp_tuser !== exp_msg.send_kind) begin
               $error("send_kind: expected %0d, got %0d", exp_msg.send_kind, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[5:0] !== exp_msg.dest_rank) begin
               $error("dest_rank: expected %0d, got %0d", exp_msg.dest_rank,
                      rsp_tdata[5:0]);
               mismatch_count++;
            end
            if (rsp_tdata[6] !== exp_msg.barrier_done) begin
               $error("barrier_done: expected %0d, got %0d", exp_msg.barrier_done,
                      rsp_tdata[6]);
               mismatch_count++;
            end
            if (rsp_tlast !== exp_msg.last_flag) begin
               $error("last: expected %0d, got %0d", exp_msg.last_flag, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/tbn_pkg.sv
rtl/core/tbn_front.sv
rtl/core/tbn_queue.sv
rtl/core/tbn_back.sv
rtl/core/tournament_barrier_node.sv
rtl/core/tbn_checker.sv
verif/tournament_barrier_node_tb.sv
